// ===== rtl/compact_offset_tree_lookup_assert.svh =====
// Assertion macros shared by the lookup RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef COMPACT_OFFSET_TREE_LOOKUP_ASSERT_SVH
`define COMPACT_OFFSET_TREE_LOOKUP_ASSERT_SVH

// Same-cycle implication.
`define COTL_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define COTL_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cotl_pkg.sv =====
// Shared types, constants and codes for the packed tree lookup.
// No dependencies; used by every module of the block except cotl_ram.
`timescale 1ns / 1ps
`default_nettype none

package cotl_pkg;

   // Default sizes of the block.
   localparam int TABLE_BYTES_DEF = 65536;
   localparam int MAX_STEPS_DEF   = 24;
   localparam int TABLES_DEF      = 4;

   // Request kinds.
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Byte encoding limits.
   localparam logic [7:0]  KEY_SHORT_MAX = 8'hde;
   localparam logic [7:0]  KEY_LONG      = 8'hdf;
   localparam logic [63:0] KEY_BIAS      = 64'd111;
   localparam logic [7:0]  PTR_SHORT_MAX = 8'hcf;
   localparam logic [7:0]  PTR_INNER_MAX = 8'hd8;
   localparam logic [7:0]  PTR_LONG_MAX  = 8'hdf;
   localparam logic [7:0]  VAL_SHORT_MAX = 8'hf7;
   localparam logic [3:0]  LONG_KEY_BYTES = 4'd8;
   localparam logic [3:0]  WIDE_FIELD_BYTES = 4'd2;

   // Kind of field being decoded.
   typedef enum logic [3:0] {
      FK_KEY  = 4'b0001,
      FK_PEEK = 4'b0010,
      FK_PTR  = 4'b0100,
      FK_VAL  = 4'b1000
   } field_type;

   // Source of the lookup result.
   typedef enum logic [2:0] {
      SEL_BEST = 3'd0,
      SEL_ONE  = 3'd1,
      SEL_LV   = 3'd2,
      SEL_OWN  = 3'd3,
      SEL_ACC  = 3'd4
   } sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      write;
      logic      start;
      logic      first;
      logic      more;
      logic      skip;
      logic      near;
      logic      act_cur;
      logic      act_jump;
      logic      act_best;
      logic      save_lk;
      logic      save_lv;
      logic      save_own;
      logic      save_rk;
      logic      res_load;
      sel_type   res_sel;
      logic      out_load;
      field_type fk;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic near9;
      logic near3;
      logic more_pend;
      logic byte_zero;
      logic acc_zero;
      logic leaf;
      logic lt_parent;
      logic lk_hit;
      logic rk_hit;
      logic tbl_bad;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/cotl_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cotl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/cotl_ctrl.sv =====
// Controller of the tree walk: state machine, walk phase and step count.
// Depends on cotl_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "compact_offset_tree_lookup_assert.svh"

module cotl_ctrl #(
   parameter int MAX_STEPS = cotl_pkg::MAX_STEPS_DEF,
   localparam int SW = $clog2(MAX_STEPS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_kind,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire cotl_pkg::sts_type sts,
   output cotl_pkg::cmd_type      cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FIELD = 7'b0000010,
      S_FIRST = 7'b0000100,
      S_NEXT  = 7'b0001000,
      S_MORE  = 7'b0010000,
      S_DONE  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   typedef enum logic [8:0] {
      P_KEY  = 9'b000000001,
      P_PEEK = 9'b000000010,
      P_PTR  = 9'b000000100,
      P_VAL  = 9'b000001000,
      P_LK   = 9'b000010000,
      P_LV   = 9'b000100000,
      P_OWN  = 9'b001000000,
      P_RK   = 9'b010000000,
      P_RV   = 9'b100000000
   } phase_type;

   localparam logic [SW-1:0] STEP_LAST = SW'(MAX_STEPS - 1);

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [SW-1:0]      step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cotl_pkg::field_type fk;
   logic               near_hit;

   // Field kind follows the walk phase.
   always_comb begin
      unique case (phase_ff)
         P_KEY, P_LK, P_RK: fk = cotl_pkg::FK_KEY;
         P_PEEK:            fk = cotl_pkg::FK_PEEK;
         P_PTR:             fk = cotl_pkg::FK_PTR;
         default:           fk = cotl_pkg::FK_VAL;
      endcase
   end

   // A field that starts too close to the end of the table reads as a fixed value; the peeked byte is exempt.
   assign near_hit = (fk == cotl_pkg::FK_KEY) ? sts.near9 :
                     (fk == cotl_pkg::FK_PEEK) ? 1'b0 : sts.near3;

   // Next-state and command logic.
   always_comb begin
      cmd          = '0;
      cmd.fk       = fk;
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == cotl_pkg::KIND_WRITE) begin
                  cmd.write = 1'b1;
               end else if (sts.tbl_bad) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = cotl_pkg::SEL_ONE;
                  state_in     = S_OUT;
               end else begin
                  cmd.start = 1'b1;
                  step_in   = '0;
                  phase_in  = P_KEY;
                  state_in  = S_FIELD;
               end
            end
         end
         S_FIELD: begin
            if (near_hit) begin
               cmd.near = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (phase_ff == P_PEEK) begin
               state_in = S_FIELD;
               if (sts.byte_zero) begin
                  cmd.skip = 1'b1;
                  phase_in = P_LK;
               end else begin
                  phase_in = P_PTR;
               end
            end else begin
               cmd.first = 1'b1;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            state_in = sts.more_pend ? S_MORE : S_DONE;
         end
         S_MORE: begin
            cmd.more = 1'b1;
            state_in = S_NEXT;
         end
         S_DONE: begin
            state_in = S_FIELD;
            unique case (phase_ff)
               P_KEY: begin
                  if (sts.acc_zero) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = cotl_pkg::SEL_BEST;
                     state_in     = S_OUT;
                  end else begin
                     cmd.act_cur = 1'b1;
                     phase_in    = sts.leaf ? P_LK : P_PEEK;
                  end
               end
               P_PTR, P_VAL: begin
                  if (phase_ff == P_PTR && !sts.lt_parent) begin
                     phase_in = P_VAL;
                  end else begin
                     cmd.act_jump = (phase_ff == P_PTR);
                     cmd.act_best = (phase_ff == P_VAL);
                     if (step_ff == STEP_LAST) begin
                        phase_in = P_LK;
                     end else begin
                        step_in  = step_ff + 1'b1;
                        phase_in = P_KEY;
                     end
                  end
               end
               P_LK: begin
                  cmd.save_lk = 1'b1;
                  phase_in    = P_LV;
               end
               P_LV: begin
                  cmd.save_lv = 1'b1;
                  phase_in    = P_OWN;
               end
               P_OWN: begin
                  cmd.save_own = 1'b1;
                  if (sts.lt_parent) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = sts.lk_hit ? cotl_pkg::SEL_LV : cotl_pkg::SEL_BEST;
                     state_in     = S_OUT;
                  end else begin
                     phase_in = P_RK;
                  end
               end
               P_RK: begin
                  cmd.save_rk = 1'b1;
                  phase_in    = P_RV;
               end
               P_RV: begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = sts.rk_hit ? cotl_pkg::SEL_ACC : cotl_pkg::SEL_OWN;
                  state_in     = S_OUT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_KEY;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Checks on the sequencing.
   `COTL_ASSERT_NXT(a_out_holds, (state_ff == S_OUT) && rsp_valid_ff && rsp_stall, state_ff == S_OUT, "result overwritten while stalled")
   `COTL_ASSERT_IMP(a_step_range, state_ff != S_IDLE, step_ff <= STEP_LAST, "step count out of range")
   `COTL_ASSERT_NXT(a_lookup_busy, req_valid && !req_stall && (req_kind == cotl_pkg::KIND_LOOKUP), state_ff != S_IDLE, "lookup request not started")
   `COTL_ASSERT_NXT(a_write_idle, req_valid && !req_stall && (req_kind == cotl_pkg::KIND_WRITE), state_ff == S_IDLE, "write request left idle")

endmodule

`default_nettype wire

// ===== rtl/cotl_dpath.sv =====
// Datapath of the tree walk: table memory, position, field decode and result.
// Depends on cotl_pkg and cotl_ram.
`timescale 1ns / 1ps
`default_nettype none

module cotl_dpath #(
   parameter int TABLE_BYTES = cotl_pkg::TABLE_BYTES_DEF,
   parameter int TABLES      = cotl_pkg::TABLES_DEF,
   localparam int DEPTH      = TABLES * TABLE_BYTES,
   localparam int MAW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire cotl_pkg::cmd_type cmd,
   output cotl_pkg::sts_type      sts,
   input  wire logic [7:0]        req_table_id,
   input  wire logic [15:0]       req_address,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic [63:0]       req_probe_key,
   output logic signed [19:0]     rsp_match_value
);

   logic [31:0]    pos_ff, pos_in;
   logic [MAW-1:0] base_ff;
   logic [63:0]    skey_ff;
   logic [31:0]    parent_ff;
   logic [19:0]    best_ff, lv_ff, own_ff, res_ff, rsp_ff;
   logic           leaf_ff, oor_ff;
   logic [63:0]    acc_ff, lk_ff, rk_ff;
   logic [3:0]     cnt_ff;
   logic           long_ff;
   logic [7:0]     rdata, rbyte;
   logic           wr_en;
   logic [MAW-1:0] wr_addr, rd_addr;
   logic [12:0]    k13;
   logic [19:0]    res_in;

   // Table memory: writes come from requests, reads follow the position.
   assign sts.tbl_bad = 32'(req_table_id) >= TABLES;
   assign wr_en   = cmd.write && !sts.tbl_bad && (32'(req_address) < TABLE_BYTES);
   assign wr_addr = MAW'(32'(req_table_id) * TABLE_BYTES + 32'(req_address));
   assign rd_addr = base_ff + pos_ff[MAW-1:0];

   cotl_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rdata)
   );

   // Bytes past the end of a table read as zero.
   assign rbyte = oor_ff ? 8'd0 : rdata;
   assign k13   = {acc_ff[4:0], rbyte};

   // Status for the controller.
   assign sts.near9     = pos_ff >= 32'(TABLE_BYTES - 9);
   assign sts.near3     = pos_ff >= 32'(TABLE_BYTES - 3);
   assign sts.more_pend = cnt_ff != 4'd0;
   assign sts.byte_zero = rbyte == 8'd0;
   assign sts.acc_zero  = acc_ff == 64'd0;
   assign sts.leaf      = leaf_ff;
   assign sts.lt_parent = skey_ff < {32'd0, parent_ff};
   assign sts.lk_hit    = (lk_ff != 64'd0) && (skey_ff >= lk_ff + {32'd0, parent_ff});
   assign sts.rk_hit    = (rk_ff != 64'd0) && (skey_ff >= rk_ff + {32'd0, parent_ff});

   // Result selection.
   always_comb begin
      unique case (cmd.res_sel)
         cotl_pkg::SEL_ONE: res_in = 20'd1;
         cotl_pkg::SEL_LV:  res_in = lv_ff;
         cotl_pkg::SEL_OWN: res_in = own_ff;
         cotl_pkg::SEL_ACC: res_in = acc_ff[19:0];
         default:           res_in = best_ff;
      endcase
   end

   // Position update.
   always_comb begin
      pos_in = pos_ff;
      if (cmd.start) begin
         pos_in = {16'd0, req_address};
      end else if (cmd.first || cmd.more || cmd.skip) begin
         pos_in = pos_ff + 32'd1;
      end else if (cmd.act_jump) begin
         pos_in = pos_ff + acc_ff[31:0];
      end
   end

   // Walk registers and field decode.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      oor_ff <= pos_ff >= 32'(TABLE_BYTES);
      if (cmd.start) begin
         base_ff   <= MAW'(32'(req_table_id) * TABLE_BYTES);
         skey_ff   <= req_probe_key;
         parent_ff <= 32'd0;
         best_ff   <= '1;
         leaf_ff   <= 1'b0;
         cnt_ff    <= 4'd0;
      end
      // Fixed values for fields that start near the table end.
      if (cmd.near) begin
         cnt_ff <= 4'd0;
         unique case (cmd.fk)
            cotl_pkg::FK_KEY: acc_ff <= 64'd0;
            cotl_pkg::FK_PTR: acc_ff <= {32'd0, 32'hffff_ffff};
            default:          acc_ff <= '1;
         endcase
      end
      // First byte of a field.
      if (cmd.first) begin
         unique case (cmd.fk)
            cotl_pkg::FK_KEY: begin
               if (rbyte <= cotl_pkg::KEY_SHORT_MAX) begin
                  acc_ff  <= {56'd0, rbyte} - cotl_pkg::KEY_BIAS;
                  cnt_ff  <= 4'd0;
                  long_ff <= 1'b0;
               end else if (rbyte == cotl_pkg::KEY_LONG) begin
                  acc_ff  <= 64'd0;
                  cnt_ff  <= cotl_pkg::LONG_KEY_BYTES;
                  long_ff <= 1'b1;
               end else begin
                  acc_ff  <= {59'd0, rbyte[4:0]};
                  cnt_ff  <= 4'd1;
                  long_ff <= 1'b0;
               end
            end
            cotl_pkg::FK_PTR: begin
               if (rbyte <= cotl_pkg::PTR_SHORT_MAX) begin
                  acc_ff  <= {56'd0, rbyte};
                  cnt_ff  <= 4'd0;
                  leaf_ff <= 1'b0;
               end else if (rbyte <= cotl_pkg::PTR_LONG_MAX) begin
                  acc_ff  <= {45'd0, rbyte[2:0], 16'd0};
                  cnt_ff  <= cotl_pkg::WIDE_FIELD_BYTES;
                  leaf_ff <= rbyte > cotl_pkg::PTR_INNER_MAX;
               end else begin
                  acc_ff  <= {59'd0, rbyte[4:0]};
                  cnt_ff  <= 4'd0;
                  leaf_ff <= 1'b1;
               end
            end
            default: begin
               if (rbyte <= cotl_pkg::VAL_SHORT_MAX) begin
                  acc_ff <= {56'd0, rbyte};
                  cnt_ff <= 4'd0;
               end else begin
                  acc_ff <= {45'd0, rbyte[2:0], 16'd0};
                  cnt_ff <= cotl_pkg::WIDE_FIELD_BYTES;
               end
            end
         endcase
      end
      // Following bytes of a field, low byte first, except that a two-byte key ends with its low byte.
      if (cmd.more) begin
         cnt_ff <= cnt_ff - 4'd1;
         if (cmd.fk == cotl_pkg::FK_KEY) begin
            if (long_ff) begin
               acc_ff <= {rbyte, acc_ff[63:8]};
            end else begin
               acc_ff <= {{51{k13[12]}}, k13};
            end
         end else if (cnt_ff == cotl_pkg::WIDE_FIELD_BYTES) begin
            acc_ff[7:0] <= rbyte;
         end else begin
            acc_ff[15:8] <= rbyte;
         end
      end
      // Actions taken once a field is complete.
      if (cmd.act_cur) begin
         parent_ff <= acc_ff[31:0] + parent_ff;
      end
      if (cmd.act_best) begin
         best_ff <= acc_ff[19:0];
      end
      if (cmd.save_lk) begin
         lk_ff <= acc_ff;
      end
      if (cmd.save_lv) begin
         lv_ff <= acc_ff[19:0];
      end
      if (cmd.save_own) begin
         own_ff <= acc_ff[19:0];
      end
      if (cmd.save_rk) begin
         rk_ff <= acc_ff;
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.out_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_match_value = $signed(rsp_ff);

endmodule

`default_nettype wire

// ===== rtl/compact_offset_tree_lookup.sv =====
// Top level of the packed tree lookup: controller plus datapath.
// Depends on cotl_pkg, cotl_ctrl, cotl_dpath and cotl_ram.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   kind, table_id, address, data_byte, probe_key
//   rsp_      out        rsp_valid/rsp_stall   match_value
//
// A table write gives no response.
// A lookup reads the table one byte at a time through the single RAM read port.
// A lookup on a missing table answers 1 without walking the tree.
// Reset is synchronous and clears the controller only; table contents stay undefined.
// A stalled response is held in its register; a new request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module compact_offset_tree_lookup #(
   parameter int TABLE_BYTES = cotl_pkg::TABLE_BYTES_DEF,
   parameter int MAX_STEPS   = cotl_pkg::MAX_STEPS_DEF,
   parameter int TABLES      = cotl_pkg::TABLES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_table_id,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [63:0] req_probe_key,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [19:0] rsp_match_value
);

   cotl_pkg::cmd_type cmd;
   cotl_pkg::sts_type sts;

   cotl_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cotl_dpath #(
      .TABLE_BYTES (TABLE_BYTES),
      .TABLES      (TABLES)
   ) u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .sts             (sts),
      .req_table_id    (req_table_id),
      .req_address     (req_address),
      .req_data_byte   (req_data_byte),
      .req_probe_key   (req_probe_key),
      .rsp_match_value (rsp_match_value)
   );

endmodule

`default_nettype wire

// ===== tb/cotl_checker.sv =====
// Shadow tree store, search predictor and response checker for the tree lookup.
// Depends on cotl_pkg; the testbench top instantiates the checker beside the block.
`timescale 1ns / 1ps
`default_nettype none

package cotl_tb_pkg;

   localparam int TBYTES = cotl_pkg::TABLE_BYTES_DEF;
   localparam int TCOUNT = cotl_pkg::TABLES_DEF;
   localparam int STEPS  = cotl_pkg::MAX_STEPS_DEF;
   localparam int TOTAL  = TBYTES * TCOUNT;

   // Shadow owners: the stimulus plans on one copy, the checker predicts on the other.
   localparam int PLAN  = 0;
   localparam int CHECK = 1;

   // Part of an encoded field that a byte belongs to.
   typedef enum int {PART_KEY, PART_KEY_TAIL, PART_PTR, PART_PTR_TAIL, PART_VAL, PART_VAL_TAIL}
      part_type;

   logic [7:0] tree_mem [2][TOTAL];
   bit         tree_set [2][TOTAL];

   // First never-written byte that the last search touched.
   bit          gap_seen;
   int unsigned gap_at;
   part_type    gap_part;

   function automatic void store_byte(int who, logic [7:0] tbl, logic [15:0] addr,
                                      logic [7:0] data);
      if (tbl < TCOUNT && addr < TBYTES) begin
         tree_mem[who][tbl * TBYTES + addr] = data;
         tree_set[who][tbl * TBYTES + addr] = 1'b1;
      end
   endfunction

   // Reads past the table give zero; unwritten bytes are noted as a gap.
   function automatic logic [7:0] tree_byte(int who, int unsigned base, logic [31:0] pos,
                                            part_type part);
      if (pos >= TBYTES) return 8'd0;
      if (!tree_set[who][base + pos]) begin
         if (!gap_seen) begin
            gap_seen = 1'b1;
            gap_at   = base + pos;
            gap_part = part;
         end
         return 8'd0;
      end
      return tree_mem[who][base + pos];
   endfunction

   function automatic logic [63:0] take_key(int who, int unsigned base, inout logic [31:0] pos);
      logic [7:0]  b;
      logic [63:0] k;
      k = 64'd0;
      if (pos >= TBYTES - 9) return 64'd0;
      b = tree_byte(who, base, pos, PART_KEY);
      pos++;
      if (b <= cotl_pkg::KEY_SHORT_MAX) begin
         k = {56'd0, b} - cotl_pkg::KEY_BIAS;
      end else if (b == cotl_pkg::KEY_LONG) begin
         for (int i = 7; i >= 0; i--)
            k = (k << 8) | tree_byte(who, base, pos + i, PART_KEY_TAIL);
         pos += 8;
      end else begin
         k = {51'd0, b[4:0], tree_byte(who, base, pos, PART_KEY_TAIL)};
         pos++;
         if (k[12]) k[63:13] = '1;
      end
      return k;
   endfunction

   function automatic logic [31:0] take_ptr(int who, int unsigned base, inout logic [31:0] pos,
                                            inout bit leaf);
      logic [7:0] b;
      logic [31:0] r;
      if (pos >= TBYTES - 3) return 32'hFFFF_FFFF;
      b = tree_byte(who, base, pos, PART_PTR);
      pos++;
      if (b <= cotl_pkg::PTR_SHORT_MAX) begin
         leaf = 1'b0;
         return {24'd0, b};
      end
      if (b <= cotl_pkg::PTR_LONG_MAX) begin
         r = {13'd0, b[2:0], tree_byte(who, base, pos + 1, PART_PTR_TAIL),
              tree_byte(who, base, pos, PART_PTR_TAIL)};
         pos += 2;
         leaf = (b > cotl_pkg::PTR_INNER_MAX);
         return r;
      end
      leaf = 1'b1;
      return {27'd0, b[4:0]};
   endfunction

   function automatic logic signed [31:0] take_val(int who, int unsigned base,
                                                   inout logic [31:0] pos);
      logic [7:0] b;
      logic signed [31:0] v;
      if (pos >= TBYTES - 3) return -1;
      b = tree_byte(who, base, pos, PART_VAL);
      pos++;
      if (b <= cotl_pkg::VAL_SHORT_MAX) return {24'd0, b};
      v = {13'd0, b[2:0], tree_byte(who, base, pos + 1, PART_VAL_TAIL),
           tree_byte(who, base, pos, PART_VAL_TAIL)};
      pos += 2;
      return v;
   endfunction

   // Walks one tree and returns the value found, cut to the response width.
   function automatic logic [19:0] tree_search(int who, logic [7:0] tbl, logic [15:0] start,
                                               logic [63:0] skey);
      int unsigned base;
      logic [31:0] pos, rel;
      logic [63:0] parent, cur, lk, rk;
      logic signed [31:0] best, lv, own, rv;
      bit leaf;
      gap_seen = 1'b0;
      if (tbl >= TCOUNT) return 20'd1;
      base   = tbl * TBYTES;
      pos    = {16'd0, start};
      parent = 64'd0;
      best   = -1;
      leaf   = 1'b0;
      // Inner walk: go left on a smaller probe key, else take the value and go right.
      for (int s = 0; s < STEPS; s++) begin
         cur = take_key(who, base, pos);
         if (cur == 0) return best[19:0];
         cur    = (cur + parent) & 64'hFFFF_FFFF;
         parent = cur;
         if (leaf) break;
         if (tree_byte(who, base, pos, PART_PTR) == 8'd0) begin
            pos++;
            break;
         end
         rel = take_ptr(who, base, pos, leaf);
         if (skey < cur) pos += rel;
         else best = take_val(who, base, pos);
      end
      // Leaf step.
      lk  = take_key(who, base, pos);
      lv  = take_val(who, base, pos);
      own = take_val(who, base, pos);
      if (skey < parent) begin
         if (lk != 0 && skey >= lk + parent) return lv[19:0];
         return best[19:0];
      end
      rk = take_key(who, base, pos);
      rv = take_val(who, base, pos);
      if (rk != 0 && skey >= rk + parent) return rv[19:0];
      return own[19:0];
   endfunction
endpackage

module cotl_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_table_id,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [63:0] req_probe_key,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [19:0] rsp_match_value,
   output int               errors,
   output int               pending
);

   logic [19:0] entry_queue[$];
   logic [19:0] want;

   initial begin
      errors  = 0;
      pending = 0;
   end

   // Track table writes, predict each lookup, and compare responses in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_kind == cotl_pkg::KIND_WRITE)
               cotl_tb_pkg::store_byte(cotl_tb_pkg::CHECK, req_table_id, req_address,
                                       req_data_byte);
            else
               entry_queue.push_back(cotl_tb_pkg::tree_search(cotl_tb_pkg::CHECK,
                                                              req_table_id, req_address,
                                                              req_probe_key));
         end
         if (rsp_valid && !rsp_stall) begin
            if (entry_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response match_value=%0d", $signed(rsp_match_value));
            end else begin
               want = entry_queue.pop_front();
               if (rsp_match_value !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("match_value mismatch: expected %0d, got %0d",
                              $signed(want), $signed(rsp_match_value));
               end
            end
         end
         pending = entry_queue.size();
      end
   end
endmodule

`default_nettype wire

// ===== tb/tb_compact_offset_tree_lookup.sv =====
// Testbench top for the tree lookup: clock, reset, request and response stimulus.
// Depends on cotl_pkg, cotl_checker.sv and the block itself.
`timescale 1ns / 1ps
`default_nettype none

module tb_compact_offset_tree_lookup;

   localparam int ITEM_GOAL = 1400;

   logic        clock, reset;
   logic        req_valid, req_stall, req_kind;
   logic [7:0]  req_table_id, req_data_byte;
   logic [15:0] req_address;
   logic [63:0] req_probe_key;
   logic        rsp_valid, rsp_stall;
   logic signed [19:0] rsp_match_value;
   int          errors, pending;
   int          items_sent = 0;
   int          send_pct = 35, recv_pct = 68;
   logic [15:0] roots [cotl_tb_pkg::TCOUNT][8];

   compact_offset_tree_lookup u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_table_id(req_table_id), .req_address(req_address),
      .req_data_byte(req_data_byte), .req_probe_key(req_probe_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_match_value(rsp_match_value)
   );

   cotl_checker u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_table_id(req_table_id), .req_address(req_address),
      .req_data_byte(req_data_byte), .req_probe_key(req_probe_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_match_value(rsp_match_value),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Bytes shaped like the field they land in, so walks go deep.
   function automatic logic [7:0] pick_byte(cotl_tb_pkg::part_type part);
      int r;
      r = $urandom_range(0, 99);
      case (part)
         cotl_tb_pkg::PART_KEY: begin
            if (r < 60) return 8'd112 + 8'($urandom_range(0, 60));
            if (r < 65) return 8'd111;
            if (r < 75) return cotl_pkg::KEY_LONG;
            if (r < 85) return 8'he0 + 8'($urandom_range(0, 31));
         end
         cotl_tb_pkg::PART_KEY_TAIL, cotl_tb_pkg::PART_PTR_TAIL: begin
            if (r < 70) return 8'($urandom_range(0, 7));
         end
         cotl_tb_pkg::PART_PTR: begin
            if (r < 50) return 8'($urandom_range(0, 24));
            if (r < 62) return 8'd0;
            if (r < 80) return 8'he0 + 8'($urandom_range(0, 31));
            if (r < 90) return 8'hd0 + 8'($urandom_range(0, 15));
         end
         cotl_tb_pkg::PART_VAL: begin
            if (r < 70) return 8'($urandom_range(0, 247));
            if (r < 85) return 8'hf8 + 8'($urandom_range(0, 7));
         end
         default: ;
      endcase
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [63:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 64'($urandom_range(0, 1200));
      if (r < 80) return 64'd0;
      if (r < 88) return '1;
      return rand64();
   endfunction

   // Offers one request from a falling edge and returns at the falling edge after it is taken.
   task automatic put_req(logic kind, logic [7:0] tbl, logic [15:0] addr, logic [7:0] data,
                          logic [63:0] skey);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_kind       = kind;
      req_table_id   = tbl;
      req_address    = addr;
      req_data_byte  = data;
      req_probe_key  = skey;
      req_valid      = 1'b1;
      if (kind == cotl_pkg::KIND_WRITE)
         cotl_tb_pkg::store_byte(cotl_tb_pkg::PLAN, tbl, addr, data);
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (items_sent == 500) begin
         send_pct = 68;
         recv_pct = 35;
      end else if (items_sent == 1000) begin
         send_pct = 0;
         recv_pct = 0;
      end
      @(negedge clock);
   endtask

   // Writes every byte the walk would touch before the lookup is sent.
   task automatic run_lookup(logic [7:0] tbl, logic [15:0] addr, logic [63:0] skey);
      forever begin
         void'(cotl_tb_pkg::tree_search(cotl_tb_pkg::PLAN, tbl, addr, skey));
         if (!cotl_tb_pkg::gap_seen) break;
         put_req(cotl_pkg::KIND_WRITE, 8'(cotl_tb_pkg::gap_at / cotl_tb_pkg::TBYTES),
                 16'(cotl_tb_pkg::gap_at % cotl_tb_pkg::TBYTES),
                 pick_byte(cotl_tb_pkg::gap_part), rand64());
      end
      put_req(cotl_pkg::KIND_LOOKUP, tbl, addr, 8'($urandom_range(0, 255)), skey);
   endtask

   // Response side: random stalls plus one long hold to back the block up.
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else if (!held && items_sent >= 300) begin
            held      = 1'b1;
            hold_left = 4000;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_pct);
         end
      end
   end

   initial begin
      int r;
      logic [7:0] tbl;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = cotl_pkg::KIND_WRITE;
      req_table_id = 8'd0;
      req_address = 16'd0;
      req_data_byte = 8'd0;
      req_probe_key = 64'd0;
      for (int t = 0; t < cotl_tb_pkg::TCOUNT; t++)
         for (int i = 0; i < 8; i++)
            roots[t][i] = 16'($urandom_range(0, 65535));
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: missing table, reads near the end, empty node, special encodings.
      put_req(cotl_pkg::KIND_WRITE, 8'hff, 16'hffff, 8'hff, '1);
      put_req(cotl_pkg::KIND_LOOKUP, 8'hff, 16'h0000, 8'h00, 64'd5);
      put_req(cotl_pkg::KIND_LOOKUP, 8'd4, 16'h1234, 8'h00, '1);
      run_lookup(8'd0, 16'hffff, '1);
      run_lookup(8'd1, 16'd65527, 64'd0);
      put_req(cotl_pkg::KIND_WRITE, 8'd0, 16'd100, 8'd111, 64'd0);
      run_lookup(8'd0, 16'd100, 64'd5);
      put_req(cotl_pkg::KIND_WRITE, 8'd0, 16'd200, 8'd121, 64'd0);
      put_req(cotl_pkg::KIND_WRITE, 8'd0, 16'd201, 8'd0, 64'd0);
      run_lookup(8'd0, 16'd200, 64'd20);
      put_req(cotl_pkg::KIND_WRITE, 8'd2, 16'd300, 8'd150, 64'd0);
      put_req(cotl_pkg::KIND_WRITE, 8'd2, 16'd301, 8'he3, 64'd0);
      put_req(cotl_pkg::KIND_WRITE, 8'd2, 16'd302, 8'hff, 64'd0);
      run_lookup(8'd2, 16'd300, 64'd100);
      put_req(cotl_pkg::KIND_WRITE, 8'd3, 16'd65525, cotl_pkg::KEY_LONG, 64'd0);
      run_lookup(8'd3, 16'd65525, 64'd0);
      run_lookup(8'd3, 16'd65525, '1);
      put_req(cotl_pkg::KIND_WRITE, 8'd1, 16'd400, 8'hff, 64'd0);
      run_lookup(8'd1, 16'd400, 64'd7);

      // Random: mostly lookups on planted roots, some noise writes, missing tables and odd starts.
      while (items_sent < ITEM_GOAL) begin
         r   = $urandom_range(0, 99);
         tbl = 8'($urandom_range(0, cotl_tb_pkg::TCOUNT - 1));
         if (r < 12)
            put_req(cotl_pkg::KIND_WRITE, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), rand64());
         else if (r < 17)
            put_req(cotl_pkg::KIND_LOOKUP, 8'($urandom_range(cotl_tb_pkg::TCOUNT, 255)),
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), rand64());
         else if (r < 27)
            run_lookup(tbl, 16'($urandom_range(0, 65535)), pick_key());
         else
            run_lookup(tbl, roots[tbl][$urandom_range(0, 7)], pick_key());
      end
      req_valid = 1'b0;

      // Drain, then allow for a last slow lookup.
      while (pending != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

`default_nettype wire

// ===== compact_offset_tree_lookup.f =====
+incdir+rtl
rtl/cotl_pkg.sv
rtl/cotl_ram.sv
rtl/cotl_ctrl.sv
rtl/cotl_dpath.sv
rtl/compact_offset_tree_lookup.sv
tb/cotl_checker.sv
tb/tb_compact_offset_tree_lookup.sv
